/* design/binary_heap_priority_queue_defines.svh */
// Assertion macros used by the checker file of the heap queue.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held low
`define BHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low
`define BHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/bhpq_pkg.sv */
`default_nettype none

package bhpq_pkg;

    localparam int KEY_W     = 32;
    localparam int PAY_W     = 32;
    localparam int COUNT_W   = 6;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [PAY_W-1:0]        t_pay;

    typedef struct packed {
        t_key key;
        t_pay pay;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // store read address source
    typedef enum logic [2:0] {
        RD_NONE   = 3'd0,
        RD_ROOT   = 3'd1,
        RD_LAST   = 3'd2,
        RD_PARENT = 3'd3,
        RD_LEFT   = 3'd4,
        RD_RIGHT  = 3'd5
    } t_rd_sel;

    // store write data source (address is always the current position)
    typedef enum logic [2:0] {
        WR_NONE = 3'd0,
        WR_RISE = 3'd1,
        WR_NEW  = 3'd2,
        WR_SINK = 3'd3,
        WR_LAST = 3'd4
    } t_wr_sel;

    // operand pair of the shared key comparator
    typedef enum logic [1:0] {
        CMP_RISE  = 2'd0,
        CMP_RIGHT = 2'd1,
        CMP_SINK  = 2'd2
    } t_cmp_sel;

    typedef struct packed {
        logic     ld_in;
        logic     start_ins;
        logic     slot_up;
        logic     cap_top;
        logic     cap_last;
        logic     cap_left;
        logic     pick_right;
        logic     sink_step;
        logic     out_load;
        t_rd_sel  rd_sel;
        t_wr_sel  wr_sel;
        t_cmp_sel cmp_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic is_remove;
        logic refused;
        logic slot_gt1;
        logic child_le_fill;
        logic child_lt_fill;
        logic above;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

/* design/binary_heap_priority_queue.sv */
// Binary heap priority queue, max-heap or min-heap by a one-bit mode register.
// Input channel (s_axis): tuser is the command (insert or remove), tdata carries
// the key and payload of an insert. Output channel (m_axis): one result per
// transaction, tuser is the status, tdata the removed entry, the count and the
// empty and full flags. Mode is written through i_cfg_wr_en/i_cfg_wr_data.
// One item is worked at a time; the store is a single RAM with one write port
// and one registered read port, and that read latency sets the pace.
// A refused item goes straight to the result; an insert steps once per level it
// rises, and a remove reads one or two children per level it examines. The next
// item is accepted on the first edge at which the result can be taken.
// A finished result waits in the output register while the next item is worked;
// if the receiver stalls, a second finished result holds in the datapath and
// the input stays blocked until that register frees up.
// Reset clears the count, the mode and the output valid; the store needs no
// clearing since no slot is read before it is written.
`default_nettype none

module binary_heap_priority_queue #(
    parameter int STORE_DEPTH = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [31:0] key, [63:32] payload
    input  wire logic [bhpq_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] command
    input  wire logic                               i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [31:0] top_key, [63:32] top_payload, [69:64] entry_count, [70] is_empty,
    // [71] is_full
    output logic      [bhpq_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // [1:0] status
    output logic      [bhpq_pkg::M_TUSER_W-1:0]     o_m_axis_tuser,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic                               i_cfg_wr_data
);

    import bhpq_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    bhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bhpq_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_s_tdata     (i_s_axis_tdata),
        .i_s_tuser     (i_s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_m_tready    (i_m_axis_tready),
        .o_m_tvalid    (o_m_axis_tvalid),
        .o_m_tdata     (o_m_axis_tdata),
        .o_m_tuser     (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

/* design/bhpq_ram.sv */
`default_nettype none

module bhpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/bhpq_ctrl.sv */
`default_nettype none

module bhpq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire bhpq_pkg::t_dp_stat i_stat,
    output bhpq_pkg::t_dp_cmd       o_cmd
);

    import bhpq_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_START    = 12'b0000_0000_0010,
        S_INS_STEP = 12'b0000_0000_0100,
        S_INS_CMP  = 12'b0000_0000_1000,
        S_RM_ROOT  = 12'b0000_0001_0000,
        S_RM_LAST  = 12'b0000_0010_0000,
        S_RM_GET   = 12'b0000_0100_0000,
        S_SD_STEP  = 12'b0000_1000_0000,
        S_SD_LEFT  = 12'b0001_0000_0000,
        S_SD_RIGHT = 12'b0010_0000_0000,
        S_SD_CMP   = 12'b0100_0000_0000,
        S_RESP     = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    // sequence the sift walks
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state     = S_START;
                end
            end
            S_START: begin
                if (i_stat.refused) begin
                    n_state = S_RESP;
                end else if (i_stat.is_remove) begin
                    n_state = S_RM_ROOT;
                end else begin
                    o_cmd.start_ins = 1'b1;
                    n_state         = S_INS_STEP;
                end
            end
            S_INS_STEP: begin
                if (i_stat.slot_gt1) begin
                    o_cmd.rd_sel = RD_PARENT;
                    n_state      = S_INS_CMP;
                end else begin
                    o_cmd.wr_sel = WR_NEW;
                    n_state      = S_RESP;
                end
            end
            S_INS_CMP: begin
                o_cmd.cmp_sel = CMP_RISE;
                if (i_stat.above) begin
                    o_cmd.wr_sel  = WR_RISE;
                    o_cmd.slot_up = 1'b1;
                    n_state       = S_INS_STEP;
                end else begin
                    o_cmd.wr_sel = WR_NEW;
                    n_state      = S_RESP;
                end
            end
            S_RM_ROOT: begin
                o_cmd.rd_sel = RD_ROOT;
                n_state      = S_RM_LAST;
            end
            S_RM_LAST: begin
                o_cmd.cap_top = 1'b1;
                o_cmd.rd_sel  = RD_LAST;
                n_state       = S_RM_GET;
            end
            S_RM_GET: begin
                o_cmd.cap_last = 1'b1;
                n_state        = S_SD_STEP;
            end
            S_SD_STEP: begin
                if (i_stat.child_le_fill) begin
                    o_cmd.rd_sel = RD_LEFT;
                    n_state      = S_SD_LEFT;
                end else begin
                    o_cmd.wr_sel = WR_LAST;
                    n_state      = S_RESP;
                end
            end
            S_SD_LEFT: begin
                o_cmd.cap_left = 1'b1;
                if (i_stat.child_lt_fill) begin
                    o_cmd.rd_sel = RD_RIGHT;
                    n_state      = S_SD_RIGHT;
                end else begin
                    n_state = S_SD_CMP;
                end
            end
            S_SD_RIGHT: begin
                o_cmd.cmp_sel    = CMP_RIGHT;
                o_cmd.pick_right = 1'b1;
                n_state          = S_SD_CMP;
            end
            S_SD_CMP: begin
                o_cmd.cmp_sel = CMP_SINK;
                if (i_stat.above) begin
                    o_cmd.wr_sel    = WR_SINK;
                    o_cmd.sink_step = 1'b1;
                    n_state         = S_SD_STEP;
                end else begin
                    o_cmd.wr_sel = WR_LAST;
                    n_state      = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/bhpq_dp.sv */
`default_nettype none

module bhpq_dp #(
    parameter int STORE_DEPTH = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire bhpq_pkg::t_dp_cmd                   i_cmd,
    output bhpq_pkg::t_dp_stat                       o_stat,
    input  wire logic [bhpq_pkg::S_TDATA_W-1:0]      i_s_tdata,
    input  wire logic                                i_s_tuser,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic                                i_cfg_wr_data,
    input  wire logic                                i_m_tready,
    output logic                                     o_m_tvalid,
    output logic      [bhpq_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic      [bhpq_pkg::M_TUSER_W-1:0]      o_m_tuser
);

    import bhpq_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic [AW-1:0] FULL_CNT = AW'(STORE_DEPTH - 1);
    localparam logic [AW-1:0] ROOT_POS = AW'(1);
    localparam logic [AW:0]   FIRST_CHILD = (AW + 1)'(2);

    // control state
    logic          r_mode;
    logic [AW-1:0] r_fill;
    logic [AW-1:0] n_fill;
    logic          r_out_valid;

    // item and walk state
    t_cmd          r_in_cmd;
    t_entry        r_in;
    t_status       r_status;
    t_status       n_status;
    logic [AW-1:0] r_pos;
    logic [AW:0]   r_child;
    t_entry        r_cand;
    logic [AW-1:0] r_cand_idx;
    t_entry        r_last;
    t_entry        r_top;

    // result register
    t_entry           r_out_top;
    logic [COUNT_W-1:0] r_out_count;
    logic             r_out_empty;
    logic             r_out_full;
    t_status          r_out_status;

    // store port signals
    logic              w_wr_en;
    logic [AW-1:0]     w_rd_addr;
    logic [ENTRY_W-1:0] w_wr_data;
    logic [ENTRY_W-1:0] w_rd_raw;
    t_entry            w_rd;
    t_key              w_cmp_a;
    t_key              w_cmp_b;
    logic              w_above;
    logic [AW+COUNT_W-1:0] w_fill_ext;

    assign w_rd = t_entry'(w_rd_raw);

    // select the read address
    always_comb begin
        case (i_cmd.rd_sel)
            RD_ROOT:   w_rd_addr = ROOT_POS;
            RD_LAST:   w_rd_addr = r_fill;
            RD_PARENT: w_rd_addr = r_pos >> 1;
            RD_LEFT:   w_rd_addr = r_child[AW-1:0];
            RD_RIGHT:  w_rd_addr = r_child[AW-1:0] + ROOT_POS;
            default:   w_rd_addr = r_pos;
        endcase
    end

    // select the write data; the address is always the current position
    always_comb begin
        w_wr_en = 1'b1;
        case (i_cmd.wr_sel)
            WR_RISE: w_wr_data = w_rd;
            WR_NEW:  w_wr_data = r_in;
            WR_SINK: w_wr_data = r_cand;
            WR_LAST: w_wr_data = r_last;
            default: begin
                w_wr_en   = 1'b0;
                w_wr_data = r_in;
            end
        endcase
    end

    bhpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_pos),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_sel != RD_NONE),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    // shared key comparator: true when a ranks above b in the current mode
    always_comb begin
        case (i_cmd.cmp_sel)
            CMP_RIGHT: begin
                w_cmp_a = w_rd.key;
                w_cmp_b = r_cand.key;
            end
            CMP_SINK: begin
                w_cmp_a = r_cand.key;
                w_cmp_b = r_last.key;
            end
            default: begin
                w_cmp_a = r_in.key;
                w_cmp_b = w_rd.key;
            end
        endcase
        w_above = r_mode ? (w_cmp_a < w_cmp_b) : (w_cmp_a > w_cmp_b);
    end

    // refuse an insert on a full heap and a remove on an empty one
    always_comb begin
        n_status = ST_OK;
        if (i_s_tuser == CMD_REMOVE) begin
            if (r_fill == '0) begin
                n_status = ST_EMPTY;
            end
        end else if (r_fill >= FULL_CNT) begin
            n_status = ST_FULL;
        end
    end

    // fill count moves on insert start and on last-entry pickup
    always_comb begin
        n_fill = r_fill;
        if (i_cmd.start_ins) begin
            n_fill = r_fill + ROOT_POS;
        end else if (i_cmd.cap_last) begin
            n_fill = r_fill - ROOT_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            r_fill <= n_fill;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_in_cmd <= t_cmd'(i_s_tuser);
            r_in.key <= i_s_tdata[KEY_W-1:0];
            r_in.pay <= i_s_tdata[KEY_W+PAY_W-1:KEY_W];
            r_status <= n_status;
            r_top    <= '0;
        end
        if (i_cmd.start_ins) begin
            r_pos <= r_fill + ROOT_POS;
        end
        if (i_cmd.slot_up) begin
            r_pos <= r_pos >> 1;
        end
        if (i_cmd.cap_top) begin
            r_top <= w_rd;
        end
        if (i_cmd.cap_last) begin
            r_last  <= w_rd;
            r_pos   <= ROOT_POS;
            r_child <= FIRST_CHILD;
        end
        if (i_cmd.cap_left) begin
            r_cand     <= w_rd;
            r_cand_idx <= r_child[AW-1:0];
        end
        if (i_cmd.pick_right && w_above) begin
            r_cand     <= w_rd;
            r_cand_idx <= r_child[AW-1:0] + ROOT_POS;
        end
        if (i_cmd.sink_step) begin
            r_pos   <= r_cand_idx;
            r_child <= {r_cand_idx, 1'b0};
        end
    end

    assign w_fill_ext = {{COUNT_W{1'b0}}, r_fill};

    // capture the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_top    <= r_top;
            r_out_count  <= w_fill_ext[COUNT_W-1:0];
            r_out_empty  <= (r_fill == '0);
            r_out_full   <= (r_fill >= FULL_CNT);
            r_out_status <= r_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_full, r_out_empty, r_out_count, r_out_top.pay, r_out_top.key};
    assign o_m_tuser  = r_out_status;

    assign o_stat.is_remove     = (r_in_cmd == CMD_REMOVE);
    assign o_stat.refused       = (r_status != ST_OK);
    assign o_stat.slot_gt1      = (r_pos > ROOT_POS);
    assign o_stat.child_le_fill = (r_child <= {1'b0, r_fill});
    assign o_stat.child_lt_fill = (r_child < {1'b0, r_fill});
    assign o_stat.above         = w_above;
    assign o_stat.out_free      = !r_out_valid || i_m_tready;

endmodule

`default_nettype wire

/* design/bhpq_checker.sv */
`default_nettype none
`include "binary_heap_priority_queue_defines.svh"

module bhpq_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_m_axis_tvalid,
    input wire logic                           i_m_axis_tready,
    input wire logic [bhpq_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic [bhpq_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);

    import bhpq_pkg::*;

    logic [KEY_W-1:0]   w_top_key;
    logic [PAY_W-1:0]   w_top_pay;
    logic [COUNT_W-1:0] w_count;
    logic               w_empty;
    logic               w_full;
    logic               w_stall;

    assign w_top_key = o_m_axis_tdata[KEY_W-1:0];
    assign w_top_pay = o_m_axis_tdata[KEY_W+PAY_W-1:KEY_W];
    assign w_count   = o_m_axis_tdata[KEY_W+PAY_W+COUNT_W-1:KEY_W+PAY_W];
    assign w_empty   = o_m_axis_tdata[KEY_W+PAY_W+COUNT_W];
    assign w_full    = o_m_axis_tdata[KEY_W+PAY_W+COUNT_W+1];
    assign w_stall   = o_m_axis_tvalid && !i_m_axis_tready;

    // a stalled result holds
    `BHPQ_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, w_stall,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser),
        "result changed while stalled")

    // a refused insert reports a full heap and no entry
    `BHPQ_ASSERT_NOW(a_full_refuse, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser == ST_FULL),
        w_full && !w_empty && (w_top_key == '0) && (w_top_pay == '0),
        "full refusal inconsistent")

    // a refused remove reports an empty heap and no entry
    `BHPQ_ASSERT_NOW(a_empty_refuse, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser == ST_EMPTY),
        w_empty && (w_top_key == '0) && (w_top_pay == '0),
        "empty refusal inconsistent")

    // empty means a zero count and not full
    `BHPQ_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, o_m_axis_tvalid && w_empty,
        (w_count == '0) && !w_full, "empty flag disagrees with count")

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (.*);

`default_nettype wire
